// File: hw/rtl/vtn_pkg.sv
// Shared constants and types for the vertex transform and normalize block.
// No dependencies; every other file of the block imports this package.
package vtn_pkg;

    localparam int NUM_CFG    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int MAT_W    = 32;
    localparam int POS_W    = 32;
    localparam int DIR_W    = 16;
    localparam int DIR_FRAC = 14;
    localparam int POS_FRAC = 16;

    localparam int PPROD_W = 2 * MAT_W;
    localparam int PSUM_W  = PPROD_W + 2;
    localparam int RND_W   = PSUM_W - POS_FRAC;

    localparam int DPROD_W  = MAT_W + DIR_W;
    localparam int VEC_W    = DPROD_W + 1;
    localparam int MAG_W    = VEC_W - 1;
    localparam int MSB_W    = 6;
    localparam int SHIFT_W  = 5;
    localparam int NORM_TOP = 29;
    localparam int U_W      = NORM_TOP + 1;
    localparam int SQ_W     = 2 * U_W;
    localparam int SSUM_W   = SQ_W + 2;

    localparam int ISQ_W         = SSUM_W + 1;
    localparam int ROOT_W        = SSUM_W / 2;
    localparam int ISQ_STEPS     = ISQ_W / 2 + 1;
    localparam int ISQ_PER_STAGE = 2;
    localparam int ISQ_STAGES    = ISQ_STEPS / ISQ_PER_STAGE;

    localparam int NUM_W         = U_W + DIR_FRAC + 1;
    localparam int Q_W           = 16;
    localparam int DIV_W         = NUM_W + 2;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = Q_W / DIV_PER_STAGE;

    localparam int DIR_LAT = 7 + ISQ_STAGES + 1 + DIV_STAGES + 1;
    localparam int POS_LAT = 3;

    localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(1 << DIR_FRAC);

    typedef logic [3:0][3:0][MAT_W-1:0] mat_t;
    typedef logic [3:0][POS_W-1:0] pos_vec_t;
    typedef logic [3:0][DIR_W-1:0] dir_vec_t;

endpackage

// File: hw/rtl/vtn_in_if.sv
// Input channel of the vertex transform block: one vertex per item.
// Depends on vtn_pkg for field widths.
interface vtn_in_if;
    import vtn_pkg::*;

    logic valid;
    logic ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] pos_w;
    logic signed [DIR_W-1:0] norm_x;
    logic signed [DIR_W-1:0] norm_y;
    logic signed [DIR_W-1:0] norm_z;
    logic signed [DIR_W-1:0] norm_w;
    logic signed [DIR_W-1:0] tang_x;
    logic signed [DIR_W-1:0] tang_y;
    logic signed [DIR_W-1:0] tang_z;
    logic signed [DIR_W-1:0] tang_w;

    modport source (
        output valid, pos_x, pos_y, pos_z, pos_w, norm_x, norm_y, norm_z, norm_w,
        output tang_x, tang_y, tang_z, tang_w,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, pos_w, norm_x, norm_y, norm_z, norm_w,
        input  tang_x, tang_y, tang_z, tang_w,
        output ready
    );
endinterface

// File: hw/rtl/vtn_out_if.sv
// Output channel of the vertex transform block: one transformed vertex per item.
// Depends on vtn_pkg for field widths.
interface vtn_out_if;
    import vtn_pkg::*;

    logic valid;
    logic ready;
    logic signed [POS_W-1:0] out_pos_x;
    logic signed [POS_W-1:0] out_pos_y;
    logic signed [POS_W-1:0] out_pos_z;
    logic signed [POS_W-1:0] out_pos_w;
    logic signed [DIR_W-1:0] out_norm_x;
    logic signed [DIR_W-1:0] out_norm_y;
    logic signed [DIR_W-1:0] out_norm_z;
    logic signed [DIR_W-1:0] out_norm_w;
    logic signed [DIR_W-1:0] out_tang_x;
    logic signed [DIR_W-1:0] out_tang_y;
    logic signed [DIR_W-1:0] out_tang_z;
    logic signed [DIR_W-1:0] out_tang_w;

    modport source (
        output valid, out_pos_x, out_pos_y, out_pos_z, out_pos_w,
        output out_norm_x, out_norm_y, out_norm_z, out_norm_w,
        output out_tang_x, out_tang_y, out_tang_z, out_tang_w,
        input  ready
    );
    modport sink (
        input  valid, out_pos_x, out_pos_y, out_pos_z, out_pos_w,
        input  out_norm_x, out_norm_y, out_norm_z, out_norm_w,
        input  out_tang_x, out_tang_y, out_tang_z, out_tang_w,
        output ready
    );
endinterface

// File: hw/rtl/vtn_pos.sv
// Position path: 4x4 matrix times position, rounded and saturated to Q16.16,
// then delayed to line up with the direction path. Depends on vtn_pkg.
module vtn_pos (
    input  logic              clk,
    input  logic              en,
    input  vtn_pkg::mat_t     mat,
    input  vtn_pkg::pos_vec_t pos_in,
    output vtn_pkg::pos_vec_t pos_out
);
    import vtn_pkg::*;

    localparam int POS_DLY = DIR_LAT - POS_LAT;

    logic signed [PPROD_W-1:0] prod_reg [4][4];
    logic signed [RND_W-1:0]   rnd_reg  [4];
    logic signed [RND_W-1:0]   rnd_next [4];
    pos_vec_t                  sat_reg;
    pos_vec_t                  sat_next;
    pos_vec_t                  dly_reg  [POS_DLY];

    always_comb
    begin
        logic signed [PSUM_W-1:0] acc;
        for (int r = 0; r < 4; r++)
        begin
            acc = PSUM_W'(1 << (POS_FRAC - 1));
            for (int c = 0; c < 4; c++)
            begin
                acc = acc + PSUM_W'(prod_reg[r][c]);
            end
            rnd_next[r] = RND_W'(acc >>> POS_FRAC);
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            if (rnd_reg[r][RND_W-1:POS_W-1] != {(RND_W-POS_W+1){rnd_reg[r][RND_W-1]}})
            begin
                sat_next[r] = rnd_reg[r][RND_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                                  : {1'b0, {(POS_W-1){1'b1}}};
            end
            else
            begin
                sat_next[r] = rnd_reg[r][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= PPROD_W'($signed(mat[r][c])) * PPROD_W'($signed(pos_in[c]));
                end
                rnd_reg[r] <= rnd_next[r];
            end
            sat_reg    <= sat_next;
            dly_reg[0] <= sat_reg;
            for (int k = 1; k < POS_DLY; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    assign pos_out = dly_reg[POS_DLY-1];

endmodule

// File: hw/rtl/vtn_isqrt.sv
// Pipelined integer square root, two result bits per stage.
// Depends on vtn_pkg; used by vtn_dir.
module vtn_isqrt (
    input  logic                       clk,
    input  logic                       en,
    input  logic [vtn_pkg::SSUM_W-1:0] radicand,
    output logic [vtn_pkg::ROOT_W-1:0] root
);
    import vtn_pkg::*;

    logic [ISQ_W-1:0] rem_reg [ISQ_STAGES];
    logic [ISQ_W-1:0] res_reg [ISQ_STAGES];

    for (genvar g = 0; g < ISQ_STAGES; g++)
    begin : g_stage
        logic [ISQ_W-1:0] rem_in;
        logic [ISQ_W-1:0] res_in;
        logic [ISQ_W-1:0] rem_next;
        logic [ISQ_W-1:0] res_next;

        if (g == 0)
        begin : g_first
            assign rem_in = ISQ_W'(radicand);
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign res_in = res_reg[g-1];
        end

        always_comb
        begin
            logic [ISQ_W-1:0] bit_c;
            logic [ISQ_W-1:0] trial;
            rem_next = rem_in;
            res_next = res_in;
            for (int k = 0; k < ISQ_PER_STAGE; k++)
            begin
                bit_c = ISQ_W'(1) << (ISQ_W - 1 - 2 * (g * ISQ_PER_STAGE + k));
                trial = res_next + bit_c;
                if (rem_next >= trial)
                begin
                    rem_next = rem_next - trial;
                    res_next = (res_next >> 1) + bit_c;
                end
                else
                begin
                    res_next = res_next >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                res_reg[g] <= res_next;
            end
        end
    end

    assign root = res_reg[ISQ_STAGES-1][ROOT_W-1:0];

endmodule

// File: hw/rtl/vtn_div.sv
// Pipelined restoring divider, two quotient bits per stage.
// Depends on vtn_pkg; used by vtn_dir.
module vtn_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [vtn_pkg::NUM_W-1:0]  num,
    input  logic [vtn_pkg::ROOT_W-1:0] den,
    output logic [vtn_pkg::Q_W-1:0]    quo
);
    import vtn_pkg::*;

    logic [DIV_W-1:0]  rem_reg [DIV_STAGES];
    logic [ROOT_W-1:0] den_reg [DIV_STAGES];
    logic [Q_W-1:0]    quo_reg [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        logic [DIV_W-1:0]  rem_in;
        logic [ROOT_W-1:0] den_in;
        logic [Q_W-1:0]    quo_in;
        logic [DIV_W-1:0]  rem_next;
        logic [Q_W-1:0]    quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = DIV_W'(num);
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        always_comb
        begin
            logic [DIV_W-1:0] d_sh;
            rem_next = rem_in;
            quo_next = quo_in;
            for (int k = 0; k < DIV_PER_STAGE; k++)
            begin
                d_sh = DIV_W'(den_in) << (Q_W - 1 - (g * DIV_PER_STAGE + k));
                if (rem_next >= d_sh)
                begin
                    rem_next = rem_next - d_sh;
                    quo_next[Q_W - 1 - (g * DIV_PER_STAGE + k)] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                den_reg[g] <= den_in;
                quo_reg[g] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

// File: hw/rtl/vtn_dir.sv
// Direction path: matrix with fourth column (0,0,0,1) times a normal or
// tangent, then scaling to unit length in Q2.14. Depends on vtn_pkg,
// vtn_isqrt and vtn_div.
module vtn_dir (
    input  logic              clk,
    input  logic              en,
    input  vtn_pkg::mat_t     mat,
    input  vtn_pkg::dir_vec_t vec_in,
    output vtn_pkg::dir_vec_t vec_out
);
    import vtn_pkg::*;

    localparam int SIDE_A_LEN = 2 + ISQ_STAGES;

    typedef struct packed {
        logic [3:0][U_W-1:0] u;
        logic [3:0]          neg;
        logic                zero;
    } side_a_t;

    typedef struct packed {
        logic [3:0] neg;
        logic       zero;
    } side_b_t;

    logic signed [DPROD_W-1:0] prod_reg [4][3];
    logic signed [VEC_W-1:0]   term_reg;
    logic signed [VEC_W-1:0]   v_reg    [4];
    logic signed [VEC_W-1:0]   v_next   [4];
    logic [MAG_W-1:0]          mag3_reg [4];
    logic [MAG_W-1:0]          mag3_next[4];
    logic [3:0]                neg3_reg;
    logic [MAG_W-1:0]          max3_reg;
    logic [MAG_W-1:0]          max_next;
    logic [MAG_W-1:0]          mag4_reg [4];
    logic [3:0]                neg4_reg;
    logic                      zero4_reg;
    logic [SHIFT_W-1:0]        rsh_reg;
    logic [SHIFT_W-1:0]        lsh_reg;
    logic [SHIFT_W-1:0]        rsh_next;
    logic [SHIFT_W-1:0]        lsh_next;
    logic [MSB_W-1:0]          msb_pos;
    side_a_t                   s5_reg;
    side_a_t                   s5_next;
    logic [SQ_W-1:0]           sq_reg   [4];
    logic [SSUM_W-1:0]         ssum_reg;
    side_a_t                   side_a_reg [SIDE_A_LEN];
    logic [ROOT_W-1:0]         root;
    logic [NUM_W-1:0]          num_reg  [4];
    logic [ROOT_W-1:0]         den_reg;
    side_b_t                   side_b_reg [DIV_STAGES + 1];
    logic [Q_W-1:0]            quo      [4];
    dir_vec_t                  out_reg;
    dir_vec_t                  out_next;

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            v_next[r] = VEC_W'(prod_reg[r][0]) + VEC_W'(prod_reg[r][1])
                      + VEC_W'(prod_reg[r][2]);
            if (r == 3)
            begin
                v_next[r] = v_next[r] + term_reg;
            end
            mag3_next[r] = v_reg[r][VEC_W-1] ? MAG_W'(-v_reg[r]) : MAG_W'(v_reg[r]);
        end
    end

    always_comb
    begin
        logic [MAG_W-1:0] m01;
        logic [MAG_W-1:0] m23;
        m01      = (mag3_next[0] > mag3_next[1]) ? mag3_next[0] : mag3_next[1];
        m23      = (mag3_next[2] > mag3_next[3]) ? mag3_next[2] : mag3_next[3];
        max_next = (m01 > m23) ? m01 : m23;
    end

    always_comb
    begin
        msb_pos = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (max3_reg[b])
            begin
                msb_pos = MSB_W'(b);
            end
        end
        if (msb_pos >= MSB_W'(NORM_TOP))
        begin
            rsh_next = SHIFT_W'(msb_pos - MSB_W'(NORM_TOP));
            lsh_next = '0;
        end
        else
        begin
            rsh_next = '0;
            lsh_next = SHIFT_W'(MSB_W'(NORM_TOP) - msb_pos);
        end
    end

    always_comb
    begin
        logic [MAG_W-1:0] shr;
        for (int i = 0; i < 4; i++)
        begin
            shr        = mag4_reg[i] >> rsh_reg;
            s5_next.u[i] = U_W'(shr << lsh_reg);
        end
        s5_next.neg  = neg4_reg;
        s5_next.zero = zero4_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (side_b_reg[DIV_STAGES].zero)
            begin
                out_next[i] = '0;
            end
            else if (side_b_reg[DIV_STAGES].neg[i])
            begin
                out_next[i] = DIR_W'(-quo[i]);
            end
            else
            begin
                out_next[i] = DIR_W'(quo[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= DPROD_W'($signed(mat[r][c])) * DPROD_W'($signed(vec_in[c]));
                end
                v_reg[r]    <= v_next[r];
                mag3_reg[r] <= mag3_next[r];
                neg3_reg[r] <= v_reg[r][VEC_W-1];
                mag4_reg[r] <= mag3_reg[r];
                sq_reg[r]   <= SQ_W'(s5_reg.u[r]) * SQ_W'(s5_reg.u[r]);
                num_reg[r]  <= (NUM_W'(side_a_reg[SIDE_A_LEN-1].u[r]) << DIR_FRAC)
                             + NUM_W'(root >> 1);
            end
            term_reg  <= VEC_W'($signed(vec_in[3])) <<< POS_FRAC;
            max3_reg  <= max_next;
            neg4_reg  <= neg3_reg;
            zero4_reg <= (max3_reg == '0);
            rsh_reg   <= rsh_next;
            lsh_reg   <= lsh_next;
            s5_reg    <= s5_next;
            ssum_reg  <= SSUM_W'(sq_reg[0]) + SSUM_W'(sq_reg[1])
                       + SSUM_W'(sq_reg[2]) + SSUM_W'(sq_reg[3]);
            side_a_reg[0] <= s5_reg;
            for (int k = 1; k < SIDE_A_LEN; k++)
            begin
                side_a_reg[k] <= side_a_reg[k-1];
            end
            den_reg            <= root;
            side_b_reg[0].neg  <= side_a_reg[SIDE_A_LEN-1].neg;
            side_b_reg[0].zero <= side_a_reg[SIDE_A_LEN-1].zero;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                side_b_reg[k] <= side_b_reg[k-1];
            end
            out_reg <= out_next;
        end
    end

    vtn_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (ssum_reg),
        .root     (root)
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        vtn_div u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (quo[i])
        );
    end

    assign vec_out = out_reg;

endmodule

// File: hw/rtl/vertex_transform_normalize.sv
// Top level of the vertex transform and normalize block.
// Depends on vtn_pkg, vtn_in_if, vtn_out_if, vtn_pos and vtn_dir.
//
// Each input item is one vertex: a Q16.16 position and a Q2.14 normal and
// tangent. Each output item carries the position times the 4x4 matrix,
// rounded and saturated, and the normal and tangent times the matrix with
// its fourth column set to (0,0,0,1), each scaled to unit length.
// The matrix sits in eight 64-bit registers written through cfg_we,
// cfg_index and cfg_data; write them only while no item is in flight.
// On the way from acceptance to output valid, the square root takes 16
// stages and each of the four dividers 8 stages.
// One item is accepted every cycle while the output is taken.
// All stages advance together; when the receiver holds ready low with a
// result waiting, the pipeline freezes and in_ch.ready drops, so no item
// is lost or repeated. Bubbles in the pipeline still move up while the
// output register is empty.
// Reset clears the matrix to zero and empties the pipeline.
module vertex_transform_normalize (
    input  logic                           clk,
    input  logic                           rst_n,
    vtn_in_if.sink                         in_ch,
    vtn_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [vtn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vtn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vtn_pkg::*;

    logic [CFG_DATA_W-1:0] mat_reg   [NUM_CFG];
    logic [DIR_LAT-1:0]    valid_reg;
    logic                  en;
    mat_t                  mat;
    pos_vec_t              pos_in;
    pos_vec_t              pos_out;
    dir_vec_t              norm_in;
    dir_vec_t              norm_out;
    dir_vec_t              tang_in;
    dir_vec_t              tang_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CFG; k++)
            begin
                mat_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                mat[r][c] = mat_reg[2 * r + (c >> 1)][MAT_W * (c & 1) +: MAT_W];
            end
        end
    end

    assign en          = out_ch.ready || !valid_reg[DIR_LAT-1];
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIR_LAT-2:0], in_ch.valid};
        end
    end

    assign pos_in  = {in_ch.pos_w, in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    assign norm_in = {in_ch.norm_w, in_ch.norm_z, in_ch.norm_y, in_ch.norm_x};
    assign tang_in = {in_ch.tang_w, in_ch.tang_z, in_ch.tang_y, in_ch.tang_x};

    vtn_pos u_pos (
        .clk     (clk),
        .en      (en),
        .mat     (mat),
        .pos_in  (pos_in),
        .pos_out (pos_out)
    );

    vtn_dir u_norm (
        .clk     (clk),
        .en      (en),
        .mat     (mat),
        .vec_in  (norm_in),
        .vec_out (norm_out)
    );

    vtn_dir u_tang (
        .clk     (clk),
        .en      (en),
        .mat     (mat),
        .vec_in  (tang_in),
        .vec_out (tang_out)
    );

    assign out_ch.valid      = valid_reg[DIR_LAT-1];
    assign out_ch.out_pos_x  = pos_out[0];
    assign out_ch.out_pos_y  = pos_out[1];
    assign out_ch.out_pos_z  = pos_out[2];
    assign out_ch.out_pos_w  = pos_out[3];
    assign out_ch.out_norm_x = norm_out[0];
    assign out_ch.out_norm_y = norm_out[1];
    assign out_ch.out_norm_z = norm_out[2];
    assign out_ch.out_norm_w = norm_out[3];
    assign out_ch.out_tang_x = tang_out[0];
    assign out_ch.out_tang_y = tang_out[1];
    assign out_ch.out_tang_z = tang_out[2];
    assign out_ch.out_tang_w = tang_out[3];

    // A unit vector never has a component beyond one in magnitude.
    a_norm_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |->
            (out_ch.out_norm_x <= DIR_ONE) && (out_ch.out_norm_x >= -DIR_ONE) &&
            (out_ch.out_norm_y <= DIR_ONE) && (out_ch.out_norm_y >= -DIR_ONE) &&
            (out_ch.out_norm_z <= DIR_ONE) && (out_ch.out_norm_z >= -DIR_ONE) &&
            (out_ch.out_norm_w <= DIR_ONE) && (out_ch.out_norm_w >= -DIR_ONE))
        else $error("normal component out of unit range");

    a_tang_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |->
            (out_ch.out_tang_x <= DIR_ONE) && (out_ch.out_tang_x >= -DIR_ONE) &&
            (out_ch.out_tang_y <= DIR_ONE) && (out_ch.out_tang_y >= -DIR_ONE) &&
            (out_ch.out_tang_z <= DIR_ONE) && (out_ch.out_tang_z >= -DIR_ONE) &&
            (out_ch.out_tang_w <= DIR_ONE) && (out_ch.out_tang_w >= -DIR_ONE))
        else $error("tangent component out of unit range");

    // With the output register empty the pipeline must be taking items.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled while output is empty");

    // An item waiting at the output keeps the whole pipeline frozen.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(valid_reg))
        else $error("pipeline moved during an output stall");

endmodule
